FILE: hw/rtl/sit_pkg.sv
// Shared widths, stage map, control struct and orientation codes for the segment test.
`default_nettype none
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;

  localparam int NUM_STAGES = 4;
  localparam int STG_DIFF   = 0;
  localparam int STG_MUL    = 1;
  localparam int STG_CLS    = 2;
  localparam int STG_OUT    = 3;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;   // stage register loads
    logic [NUM_STAGES-1:0] vld;  // stage holds a beat
  } pipe_ctl_t;

  typedef enum logic [1:0] {
    ORI_ZERO = 2'b00,
    ORI_NEG  = 2'b01,
    ORI_POS  = 2'b10
  } ori_e;

  // Product of two classes is at most zero.
  function automatic logic ori_prod_le0(input ori_e a, input ori_e b);
    logic res;
    res = (a == ORI_ZERO) || (b == ORI_ZERO) || (a != b);
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sit_ctrl.sv
// Valid bits and per-stage load enables for the segment test pipeline.
`default_nettype none
module sit_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_ready_i,
  output sit_pkg::pipe_ctl_t     ctl_o
);
  import sit_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o = '{en: en, vld: valid_q};

endmodule
`default_nettype wire

FILE: hw/rtl/sit_orient.sv
// One orientation lane: classify point P against segment S0->S1 in three stages.
`default_nettype none
module sit_orient (
  input  wire logic                                 clk_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] s0x_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] s0y_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] s1x_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] s1y_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] px_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] py_i,
  input  wire sit_pkg::pipe_ctl_t                   ctl_i,
  output sit_pkg::ori_e                             cls_o
);
  import sit_pkg::*;

  // Stage 1: direction d, offset q from start, offset r from end.
  logic signed [DIFF_WIDTH-1:0] dx_d, dy_d, qx_d, qy_d, rx_d, ry_d;
  logic signed [DIFF_WIDTH-1:0] dx_q, dy_q, qx_q, qy_q, rx_q, ry_q;

  assign dx_d = $signed({s1x_i[COORD_WIDTH-1], s1x_i}) - $signed({s0x_i[COORD_WIDTH-1], s0x_i});
  assign dy_d = $signed({s1y_i[COORD_WIDTH-1], s1y_i}) - $signed({s0y_i[COORD_WIDTH-1], s0y_i});
  assign qx_d = $signed({px_i[COORD_WIDTH-1], px_i}) - $signed({s0x_i[COORD_WIDTH-1], s0x_i});
  assign qy_d = $signed({py_i[COORD_WIDTH-1], py_i}) - $signed({s0y_i[COORD_WIDTH-1], s0y_i});
  assign rx_d = $signed({px_i[COORD_WIDTH-1], px_i}) - $signed({s1x_i[COORD_WIDTH-1], s1x_i});
  assign ry_d = $signed({py_i[COORD_WIDTH-1], py_i}) - $signed({s1y_i[COORD_WIDTH-1], s1y_i});

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_DIFF]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  // Stage 2: the six partial products.
  logic signed [PROD_WIDTH-1:0] cr0_d, cr1_d, dt0_d, dt1_d, de0_d, de1_d;
  logic signed [PROD_WIDTH-1:0] cr0_q, cr1_q, dt0_q, dt1_q, de0_q, de1_q;

  assign cr0_d = qx_q * dy_q;
  assign cr1_d = qy_q * dx_q;
  assign dt0_d = qx_q * dx_q;
  assign dt1_d = qy_q * dy_q;
  assign de0_d = rx_q * dx_q;
  assign de1_d = ry_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_MUL]) begin
      cr0_q <= cr0_d;
      cr1_q <= cr1_d;
      dt0_q <= dt0_d;
      dt1_q <= dt1_d;
      de0_q <= de0_d;
      de1_q <= de1_d;
    end
  end

  // Stage 3: cross, dot from start, dot from end, then the class.
  logic signed [SUM_WIDTH-1:0] cross_s, dot_s, dend_s;
  ori_e cls_d, cls_q;

  assign cross_s = $signed({cr0_q[PROD_WIDTH-1], cr0_q}) - $signed({cr1_q[PROD_WIDTH-1], cr1_q});
  assign dot_s   = $signed({dt0_q[PROD_WIDTH-1], dt0_q}) + $signed({dt1_q[PROD_WIDTH-1], dt1_q});
  assign dend_s  = $signed({de0_q[PROD_WIDTH-1], de0_q}) + $signed({de1_q[PROD_WIDTH-1], de1_q});

  always_comb begin
    if (cross_s != '0) begin
      cls_d = cross_s[SUM_WIDTH-1] ? ORI_NEG : ORI_POS;
    end else if (dot_s[SUM_WIDTH-1]) begin
      cls_d = ORI_NEG;                 // behind the start
    end else if (dot_s == '0) begin
      cls_d = ORI_ZERO;
    end else if (!dend_s[SUM_WIDTH-1] && dend_s != '0) begin
      cls_d = ORI_POS;                 // beyond the end
    end else begin
      cls_d = ORI_ZERO;                // on the segment
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_CLS]) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o = cls_q;

endmodule
`default_nettype wire

FILE: hw/rtl/segment_intersection_test.sv
// Top level of the segment intersection test: four orientation lanes and the result stage.
//
// Takes one beat per clock, while in_ready_o is high, holding two segments A and B
// (16-bit two's complement endpoints) and returns one beat per input: contiguous
// is set when A's start equals B's end or A's end equals B's start, and crosses
// is set when the pair is not contiguous and each segment's endpoints lie on
// opposite sides of, or touch, the other segment (collinear points are classed
// as behind the start, on the segment, or beyond the end). Arithmetic is exact.
// The pipeline has four register stages (differences, products, sums and
// classes, result). Each stage advances on its own, so bubbles are squeezed out
// and in_ready_o drops only when all four stages hold beats and the output beat
// is not being taken. Reset clears only the valid bits.
`default_nettype none
module segment_intersection_test (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] a_start_x_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] a_start_y_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] a_end_x_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] a_end_y_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] b_start_x_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] b_start_y_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] b_end_x_i,
  input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] b_end_y_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      crosses_o,
  output logic                                      contiguous_o
);
  import sit_pkg::*;

  pipe_ctl_t ctl;

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  assign in_ready_o  = ctl.en[STG_DIFF];
  assign out_valid_o = ctl.vld[STG_OUT];

  // Classes of B's endpoints against A, and of A's endpoints against B.
  ori_e cls_bs_a, cls_be_a, cls_as_b, cls_ae_b;

  sit_orient u_bs_vs_a (
    .clk_i (clk_i),
    .s0x_i (a_start_x_i), .s0y_i (a_start_y_i),
    .s1x_i (a_end_x_i),   .s1y_i (a_end_y_i),
    .px_i  (b_start_x_i), .py_i  (b_start_y_i),
    .ctl_i (ctl),
    .cls_o (cls_bs_a)
  );

  sit_orient u_be_vs_a (
    .clk_i (clk_i),
    .s0x_i (a_start_x_i), .s0y_i (a_start_y_i),
    .s1x_i (a_end_x_i),   .s1y_i (a_end_y_i),
    .px_i  (b_end_x_i),   .py_i  (b_end_y_i),
    .ctl_i (ctl),
    .cls_o (cls_be_a)
  );

  sit_orient u_as_vs_b (
    .clk_i (clk_i),
    .s0x_i (b_start_x_i), .s0y_i (b_start_y_i),
    .s1x_i (b_end_x_i),   .s1y_i (b_end_y_i),
    .px_i  (a_start_x_i), .py_i  (a_start_y_i),
    .ctl_i (ctl),
    .cls_o (cls_as_b)
  );

  sit_orient u_ae_vs_b (
    .clk_i (clk_i),
    .s0x_i (b_start_x_i), .s0y_i (b_start_y_i),
    .s1x_i (b_end_x_i),   .s1y_i (b_end_y_i),
    .px_i  (a_end_x_i),   .py_i  (a_end_y_i),
    .ctl_i (ctl),
    .cls_o (cls_ae_b)
  );

  // Contiguity is known at the first stage and rides along with the lanes.
  logic contig_d;
  logic contig1_q, contig2_q, contig3_q;

  assign contig_d = ((a_start_x_i == b_end_x_i) && (a_start_y_i == b_end_y_i)) ||
                    ((a_end_x_i == b_start_x_i) && (a_end_y_i == b_start_y_i));

  always_ff @(posedge clk_i) begin
    if (ctl.en[STG_DIFF]) begin
      contig1_q <= contig_d;
    end
    if (ctl.en[STG_MUL]) begin
      contig2_q <= contig1_q;
    end
    if (ctl.en[STG_CLS]) begin
      contig3_q <= contig2_q;
    end
  end

  // Result stage doubles as the output register.
  logic crosses_d, crosses_q, contiguous_q;

  assign crosses_d = !contig3_q &&
                     ori_prod_le0(cls_bs_a, cls_be_a) &&
                     ori_prod_le0(cls_as_b, cls_ae_b);

  always_ff @(posedge clk_i) begin
    if (ctl.en[STG_OUT]) begin
      crosses_q    <= crosses_d;
      contiguous_q <= contig3_q;
    end
  end

  assign crosses_o    = crosses_q;
  assign contiguous_o = contiguous_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sit_checker.sv
// Port-level checks for the segment intersection test, bound to the top level.
`default_nettype none
module sit_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic crosses_o,
  input wire logic contiguous_o
);

  // Input side backs up only behind a blocked output beat.
  a_stall_only_when_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i)
  ) else $error("input stalled while output not blocked");

  // A fresh output beat follows an accepted input beat.
  a_fill_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 4)
  ) else $error("output beat without matching input beat");

  // A contiguous pair never reports a crossing.
  a_flags_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(crosses_o && contiguous_o)
  ) else $error("crosses and contiguous both set");

  // A blocked output beat holds.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(crosses_o) && $stable(contiguous_o))
  ) else $error("output beat changed while stalled");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .crosses_o    (crosses_o),
  .contiguous_o (contiguous_o)
);
`default_nettype wire
